// File: rtl/fgs_pkg.sv
// Package for the character-rounding glyph converter: mode codes, the per-row
// control struct and the pixel functions used by the row converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fgs_pkg;

   // Font mode codes; the unused code three behaves like the masking mode.
   localparam logic [1:0] MODE_MASK    = 2'd0;
   localparam logic [1:0] MODE_SMOOTH  = 2'd1;
   localparam logic [1:0] MODE_STRETCH = 2'd2;

   localparam int ROW_BITS   = 6;
   localparam int GLYPH_BITS = 60;

   // Control that travels with the row at the head of the chain.
   typedef struct packed {
      logic [1:0] mode;
      logic       graphic;
      logic       first;
      logic       last;
   } fgs_row_ctl_type;

   // Triple each of the five low text pixels into three output pixels.
   function automatic logic [15:0] triple_pixels(input logic [ROW_BITS-1:0] c);
      logic [15:0] k;
      k = '0;
      for (int b = 0; b <= 4; b++) begin
         if (c[b]) begin
            k[3*b +: 3] = 3'b111;
         end
      end
      return k;
   endfunction

   // Diagonal fill pixels for row c taken from the neighboring row d.
   function automatic logic [15:0] diag_fills(input logic [ROW_BITS-1:0] c,
                                              input logic [ROW_BITS-1:0] d);
      logic [15:0] f;
      f = '0;
      for (int b = 1; b <= 4; b++) begin
         f[3*b-1] = c[b] & d[b-1] & ~d[b];
         f[3*b]   = d[b] & c[b-1] & ~d[b-1];
      end
      return f;
   endfunction

endpackage

`default_nettype wire

// File: rtl/fgs_if.sv
// Handshake interfaces for the glyph, row result and mode register channels.
// Depends on nothing; widths follow the fixed field widths of the block.
`timescale 1ns / 1ps
`default_nettype none

interface fgs_req_if;
   logic        valid;
   logic        ready;
   logic [59:0] glyph_rows;
   logic        is_graphic;
   modport source (output valid, output glyph_rows, output is_graphic, input ready);
   modport sink (input valid, input glyph_rows, input is_graphic, output ready);
endinterface

interface fgs_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  row_index;
   logic [15:0] row_top;
   logic [15:0] row_bottom;
   logic        last;
   modport source (output valid, output row_index, output row_top, output row_bottom,
                   output last, input ready);
   modport sink (input valid, input row_index, input row_top, input row_bottom,
                 input last, output ready);
endinterface

interface fgs_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] font_mode;
   modport source (output valid, output font_mode, input ready);
   modport sink (input valid, input font_mode, output ready);
endinterface

`default_nettype wire

// File: rtl/fgs_cell.sv
// One cell of the glyph row chain: holds one 6-bit row, loads it from the
// incoming glyph and passes it toward the head on each shift. Uses fgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fgs_cell (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic                         shift,
   input  wire logic [fgs_pkg::ROW_BITS-1:0] load_row,
   input  wire logic [fgs_pkg::ROW_BITS-1:0] right_row,
   output logic      [fgs_pkg::ROW_BITS-1:0] row
);
   import fgs_pkg::*;

   logic [ROW_BITS-1:0] row_ff;
   logic [ROW_BITS-1:0] row_in;

   // A new glyph wins over the shift; otherwise take the neighbor's row.
   always_comb begin
      row_in = row_ff;
      if (load) begin
         row_in = load_row;
      end else if (shift) begin
         row_in = right_row;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row = row_ff;

endmodule

`default_nettype wire

// File: rtl/fgs_row_conv.sv
// Row converter at the head of the chain: turns one glyph row and its two
// neighbors into the top and bottom output rows. Uses fgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fgs_row_conv (
   input  wire fgs_pkg::fgs_row_ctl_type         ctl,
   input  wire logic [fgs_pkg::ROW_BITS-1:0]     cur_row,
   input  wire logic [fgs_pkg::ROW_BITS-1:0]     prev_row,
   input  wire logic [fgs_pkg::ROW_BITS-1:0]     next_row,
   output logic      [15:0]                      row_top,
   output logic      [15:0]                      row_bottom
);
   import fgs_pkg::*;

   logic [15:0] gfx_block;
   logic [15:0] tripled;

   // Mosaic blocks expand straight into both halves.
   always_comb begin
      gfx_block = '0;
      if (cur_row[5]) begin
         gfx_block = gfx_block | 16'hC000;
      end
      if (|cur_row[4:3]) begin
         gfx_block = gfx_block | 16'h3F00;
      end
      if (cur_row[2]) begin
         gfx_block = gfx_block | 16'h00C0;
      end
      if (|cur_row[1:0]) begin
         gfx_block = gfx_block | 16'h003F;
      end
   end

   assign tripled = triple_pixels(cur_row);

   // Select the conversion for the current font mode.
   always_comb begin
      row_top    = {10'd0, cur_row};
      row_bottom = '0;
      case (ctl.mode)
         MODE_STRETCH: begin
            if (ctl.graphic) begin
               row_top = {8'd0, cur_row[5:3], cur_row[4], cur_row[2:0], cur_row[0]};
            end else begin
               row_top = {9'd0, cur_row, 1'b0};
            end
         end
         MODE_SMOOTH: begin
            if (ctl.graphic) begin
               row_top    = gfx_block;
               row_bottom = gfx_block;
            end else begin
               row_top    = tripled;
               row_bottom = tripled;
               if (!ctl.first) begin
                  row_top = tripled | diag_fills(cur_row, prev_row);
               end
               if (!ctl.last) begin
                  row_bottom = tripled | diag_fills(cur_row, next_row);
               end
            end
         end
         default: begin
            row_top    = {10'd0, cur_row};
            row_bottom = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/font_glyph_smoothing_stretch.sv
// Character-rounding glyph converter, top level. Uses fgs_pkg, the fgs
// interfaces, fgs_cell and fgs_row_conv.
`timescale 1ns / 1ps
`default_nettype none

// A glyph of ROWS_PER_GLYPH six-pixel rows is loaded into a chain of row
// cells in one transfer; the chain then shifts one row per cycle, while the
// result register can take it, past the row converter, which sees the
// previous and next rows for the mode 1 diagonal fills. Each converted row
// goes to a result register that feeds the single result port, which carries
// one row per cycle. The next glyph is taken in the cycle that the last row of
// the current one leaves the chain, so glyphs run back to back while the
// result side keeps up. The mode register is written through the csr channel,
// which is always ready, and should change only while idle.
module font_glyph_smoothing_stretch #(
   parameter int ROWS_PER_GLYPH = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   fgs_req_if.sink   req_bus,
   fgs_rsp_if.source rsp_bus,
   fgs_csr_if.sink   csr_bus
);
   import fgs_pkg::*;

   localparam int CNT_W = $clog2(ROWS_PER_GLYPH + 1);

   logic [1:0]          font_mode_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [3:0]          idx_ff, idx_in;
   logic                graphic_ff, graphic_in;
   logic [ROW_BITS-1:0] prev_ff, prev_in;

   logic                rsp_valid_ff;
   logic [3:0]          rsp_index_ff;
   logic [15:0]         rsp_top_ff;
   logic [15:0]         rsp_bottom_ff;
   logic                rsp_last_ff;

   logic [ROW_BITS-1:0] cell_row [ROWS_PER_GLYPH];
   logic                out_free;
   logic                advance;
   logic                accept;
   fgs_row_ctl_type     head_ctl;
   logic [15:0]         conv_top;
   logic [15:0]         conv_bottom;

   // Mode register.
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         font_mode_ff <= MODE_MASK;
      end else if (csr_bus.valid) begin
         font_mode_ff <= csr_bus.font_mode;
      end
   end

   // Handshake: the head row moves when the result register can take it.
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = (cnt_ff != '0) && out_free;
   assign req_bus.ready = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && out_free);
   assign accept        = req_bus.valid && req_bus.ready;

   // Row cells; the tail cell shifts in zeros.
   for (genvar i = 0; i < ROWS_PER_GLYPH; i++) begin : g_cell
      logic [ROW_BITS-1:0] right_row;
      if (i == ROWS_PER_GLYPH - 1) begin : g_tail
         assign right_row = '0;
      end else begin : g_mid
         assign right_row = cell_row[i+1];
      end
      fgs_cell u_cell (
         .clock     (clock),
         .load      (accept),
         .shift     (advance),
         .load_row  (req_bus.glyph_rows[ROW_BITS*i +: ROW_BITS]),
         .right_row (right_row),
         .row       (cell_row[i])
      );
   end

   // Converter at the head of the chain.
   assign head_ctl.mode    = font_mode_ff;
   assign head_ctl.graphic = graphic_ff;
   assign head_ctl.first   = (idx_ff == '0);
   assign head_ctl.last    = (idx_ff == 4'(ROWS_PER_GLYPH - 1));

   fgs_row_conv u_conv (
      .ctl        (head_ctl),
      .cur_row    (cell_row[0]),
      .prev_row   (prev_ff),
      .next_row   (cell_row[1]),
      .row_top    (conv_top),
      .row_bottom (conv_bottom)
   );

   // Row count, row index and previous row for the glyph in the chain.
   always_comb begin
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      graphic_in = graphic_ff;
      prev_in    = prev_ff;
      if (accept) begin
         cnt_in     = CNT_W'(ROWS_PER_GLYPH);
         idx_in     = '0;
         graphic_in = req_bus.is_graphic;
         prev_in    = '0;
      end else if (advance) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         idx_in  = idx_ff + 4'd1;
         prev_in = cell_row[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
      graphic_ff <= graphic_in;
      prev_ff    <= prev_in;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_index_ff  <= idx_ff;
         rsp_top_ff    <= conv_top;
         rsp_bottom_ff <= conv_bottom;
         rsp_last_ff   <= head_ctl.last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.row_index  = rsp_index_ff;
   assign rsp_bus.row_top    = rsp_top_ff;
   assign rsp_bus.row_bottom = rsp_bottom_ff;
   assign rsp_bus.last       = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/fgs_checker.sv
// Port-level checks for the glyph converter, attached to the top level by a
// bind statement. Depends on font_glyph_smoothing_stretch and its interfaces.
`timescale 1ns / 1ps
`default_nettype none

module fgs_checker #(
   parameter int ROWS_PER_GLYPH = 10
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_index,
   input wire logic [15:0] rsp_top,
   input wire logic        rsp_last
);

   // A stalled result keeps its row.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index) && $stable(rsp_top))
      else $error("stalled result changed");

   // The last flag marks exactly the final row of a glyph.
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_index == 4'(ROWS_PER_GLYPH - 1))))
      else $error("last flag does not match row index");

   // Row indexes stay within the glyph.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_index <= 4'(ROWS_PER_GLYPH - 1)))
      else $error("row index beyond glyph");

   // A glyph transfer fills the chain, so the next glyph waits.
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("glyph taken while chain full");

endmodule

bind font_glyph_smoothing_stretch fgs_checker #(.ROWS_PER_GLYPH(ROWS_PER_GLYPH)) u_fgs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_index (rsp_bus.row_index),
   .rsp_top   (rsp_bus.row_top),
   .rsp_last  (rsp_bus.last)
);

`default_nettype wire
